// ----- src/b64e_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  // character codes
  localparam logic [6:0] CHAR_CR  = 7'h0D;
  localparam logic [6:0] CHAR_LF  = 7'h0A;
  localparam logic [6:0] CHAR_PAD = 7'h3D;

  // line count past which a finished group closes the line
  localparam logic [6:0] LINE_LIMIT = 7'd72;
  localparam logic [6:0] LINE_MAX   = 7'd127;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // position within the 3-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // characters produced by one byte, handed from front to back
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;
    logic            msg_end;
  } job_t;

  // base64 alphabet lookup
  function automatic logic [6:0] sym(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      r = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      r = 7'h2B;
    end else begin
      r = 7'h2F;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/b64e_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source(output valid, output data_byte, output final_byte, input ready);
  modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_end;
  logic       message_end;
  modport source(output valid, output out_char, output run_end, output message_end,
                 input ready);
  modport sink(input valid, input out_char, input run_end, input message_end,
               output ready);
endinterface

`default_nettype wire

// ----- src/b64e_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  b64e_byte_if.sink         bytes,
  output logic              push,
  output b64e_pkg::job_t    push_job,
  input  wire logic         full
);

  logic             wrap_lines;
  b64e_pkg::phase_t phase, phase_next;
  logic [3:0]       leftover, leftover_next;
  logic [6:0]       line_chars, line_chars_next;
  logic [7:0]       lc_sum;
  logic [6:0]       lc_sat;
  logic [7:0]       b;
  logic             last;

  assign b           = bytes.data_byte;
  assign last        = bytes.final_byte;
  assign bytes.ready = !full;
  assign push        = bytes.valid && !full;

  assign lc_sum = {1'b0, line_chars} + 8'd4;
  assign lc_sat = lc_sum[7] ? b64e_pkg::LINE_MAX : lc_sum[6:0];

  // next group position
  always_comb begin
    case (phase)
      b64e_pkg::PH_SECOND: phase_next = b64e_pkg::PH_THIRD;
      b64e_pkg::PH_THIRD:  phase_next = b64e_pkg::PH_FIRST;
      default:             phase_next = b64e_pkg::PH_SECOND;
    endcase
    if (last) begin
      phase_next = b64e_pkg::PH_FIRST;
    end
  end

  // characters and leftover bits
  always_comb begin
    push_job.chars    = {4{b64e_pkg::CHAR_PAD}};
    push_job.last_idx = 2'd0;
    push_job.msg_end  = last;
    leftover_next     = 4'd0;
    line_chars_next   = line_chars;
    case (phase)
      b64e_pkg::PH_SECOND: begin
        push_job.chars[0] = b64e_pkg::sym({leftover[1:0], b[7:4]});
        leftover_next     = b[3:0];
        if (last) begin
          push_job.chars[1] = b64e_pkg::sym({b[3:0], 2'b00});
          push_job.last_idx = 2'd2;
        end
      end
      b64e_pkg::PH_THIRD: begin
        push_job.chars[0] = b64e_pkg::sym({leftover, b[7:6]});
        push_job.chars[1] = b64e_pkg::sym(b[5:0]);
        push_job.last_idx = 2'd1;
        line_chars_next   = lc_sat;
        if (wrap_lines && (lc_sat > b64e_pkg::LINE_LIMIT)) begin
          push_job.chars[2] = b64e_pkg::CHAR_CR;
          push_job.chars[3] = b64e_pkg::CHAR_LF;
          push_job.last_idx = 2'd3;
          line_chars_next   = 7'd0;
        end
      end
      default: begin
        push_job.chars[0] = b64e_pkg::sym(b[7:2]);
        leftover_next     = {2'b00, b[1:0]};
        if (last) begin
          push_job.chars[1] = b64e_pkg::sym({b[1:0], 4'b0000});
          push_job.last_idx = 2'd3;
        end
      end
    endcase
    if (last) begin
      leftover_next   = 4'd0;
      line_chars_next = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_lines <= 1'b0;
      phase      <= b64e_pkg::PH_FIRST;
      leftover   <= 4'd0;
      line_chars <= 7'd0;
    end else begin
      if (cfg_we) begin
        wrap_lines <= cfg_wdata;
      end
      if (push) begin
        phase      <= phase_next;
        leftover   <= leftover_next;
        line_chars <= line_chars_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/b64e_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64e_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output b64e_pkg::job_t       pop_job,
  output logic                 not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = entries[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/b64e_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire b64e_pkg::job_t  q_job,
  output logic                 pop,
  b64e_char_if.source          chars
);

  b64e_pkg::job_t cur;
  logic           cur_valid;
  logic [1:0]     idx;
  logic           at_last;
  logic           take;

  assign at_last = (idx == cur.last_idx);
  assign take    = chars.valid && chars.ready;
  assign pop     = q_valid && (!cur_valid || (take && at_last));

  assign chars.valid       = cur_valid;
  assign chars.out_char    = cur.chars[idx];
  assign chars.run_end     = at_last;
  assign chars.message_end = at_last && cur.msg_end;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (take) begin
        if (at_last) begin
          cur_valid <= 1'b0;
          idx       <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/base64_stream_encoder.sv -----
// Base64 stream encoder with optional CR LF line wrapping. Message bytes enter on the byte
// channel one word at a time, the last byte flagged by final_byte; encoded ASCII characters
// leave on the char channel one word per cycle while ready is high, with run_end on the last
// character caused by a byte and message_end on the last character of the message. A final
// byte flushes the partial group with '=' padding and clears the group and line state. With
// wrap_lines set, CR LF follows each full group that takes the line past 72 characters
// (76-character lines). A byte is taken whenever the queue has room; the output side sends
// one character per cycle while ready is high, and a byte causes 1 to 4 characters (4/3 on
// average plus line breaks), so the single-character output port sets the sustained rate.
// Write wrap_lines only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  // wrap_lines register
  input  wire logic    cfg_we,
  input  wire logic    cfg_wdata,
  b64e_byte_if.sink    byte_ch,
  b64e_char_if.source  char_ch
);

  // front to queue
  logic           push;
  b64e_pkg::job_t push_job;
  logic           full;

  // queue to back
  logic           pop;
  b64e_pkg::job_t pop_job;
  logic           not_empty;

  // front: takes a byte, updates group phase, leftover bits and line count,
  // and builds the list of up to four characters it causes
  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bytes     (byte_ch),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  // short queue so the byte side keeps moving while characters drain
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (not_empty)
  );

  // back: holds one character list in a register and sends it out a
  // character per cycle while ready is high, loading the next list on the last character
  b64e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (not_empty),
    .q_job   (pop_job),
    .pop     (pop),
    .chars   (char_ch)
  );

endmodule

`default_nettype wire

// ----- src/b64e_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64e_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_char,
  input wire logic       run_end,
  input wire logic       message_end
);

  // end of message always closes a byte's run
  a_msg_end_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> run_end)
    else $error("message_end without run_end");

  // a CR never ends a run; it is followed by LF from the same byte
  a_cr_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_char == b64e_pkg::CHAR_CR) |-> !run_end)
    else $error("CR ends a run");

  // only alphabet, pad, CR or LF leave the block
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_char >= 7'h41) && (out_char <= 7'h5A)) ||
                  ((out_char >= 7'h61) && (out_char <= 7'h7A)) ||
                  ((out_char >= 7'h30) && (out_char <= 7'h39)) ||
                  (out_char == 7'h2B) || (out_char == 7'h2F) ||
                  (out_char == b64e_pkg::CHAR_PAD) ||
                  (out_char == b64e_pkg::CHAR_CR) || (out_char == b64e_pkg::CHAR_LF))
    else $error("illegal output character");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_end)
                                && $stable(message_end))
    else $error("stalled word changed");

endmodule

bind base64_stream_encoder b64e_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (char_ch.valid),
  .out_ready   (char_ch.ready),
  .out_char    (char_ch.out_char),
  .run_end     (char_ch.run_end),
  .message_end (char_ch.message_end)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // one word on the byte channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  // one word on the char channel
  typedef struct packed {
    logic [6:0] ch;
    logic       run_end;
    logic       msg_end;
  } char_word_t;

  // standard alphabet, index 0 in the top byte
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  localparam int IDLE_PCT = 36;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  b64e_byte_if byte_if ();
  b64e_char_if char_if ();

  base64_stream_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_ch   (byte_if),
    .char_ch   (char_if)
  );

  // bytes waiting to be sent; head is the word on the bus while valid is high
  byte_word_t pending_bytes[$];
  // characters the encoder still owes us, oldest first
  char_word_t expected_chars[$];
  char_word_t next_char;

  // our own copy of the encoder state and the wrap register
  b64e_pkg::phase_t grp_phase;
  logic [3:0]       spare_bits;
  logic [6:0]       line_count;
  logic             wrap_on;

  // traffic shaping knobs set by the stimulus block, plus the taken flag and error count
  bit no_gaps;
  bit hold_sender;
  bit byte_taken;
  int fail_count;

  // 4 ns clock
  always #2 clk = ~clk;

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = 8'h00;
    byte_if.final_byte = 1'b0;
    char_if.ready      = 1'b0;
    no_gaps           = 1'b0;
    hold_sender       = 1'b0;
    byte_taken        = 1'b0;
    fail_count        = 0;
    grp_phase         = b64e_pkg::PH_FIRST;
    spare_bits        = '0;
    line_count        = '0;
    wrap_on           = 1'b0;
  end

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    return B64_ALPHABET[8 * (63 - int'(v)) +: 7];
  endfunction

  // work out the characters one accepted byte should produce and queue them up
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [6:0] chars [4];
    int         n;
    char_word_t w;
    n = 0;
    case (grp_phase)
      b64e_pkg::PH_SECOND: begin
        // low 2 bits of the first byte with the high nibble of this one
        chars[0]   = b64_char({spare_bits[1:0], b[7:4]});
        n          = 1;
        spare_bits = b[3:0];
        grp_phase  = b64e_pkg::PH_THIRD;
        if (last) begin
          // two bytes in the group: flush and one pad
          chars[1] = b64_char({b[3:0], 2'b00});
          chars[2] = b64e_pkg::CHAR_PAD;
          n        = 3;
        end
      end
      b64e_pkg::PH_THIRD: begin
        // group complete: two characters and the line count moves by a group
        chars[0]   = b64_char({spare_bits, b[7:6]});
        chars[1]   = b64_char(b[5:0]);
        n          = 2;
        spare_bits = '0;
        grp_phase  = b64e_pkg::PH_FIRST;
        // the count keeps running with wrap off and sticks at its max
        line_count = (line_count > b64e_pkg::LINE_MAX - 7'd4) ? b64e_pkg::LINE_MAX :
                     line_count + 7'd4;
        if (wrap_on && line_count > b64e_pkg::LINE_LIMIT) begin
          chars[2]   = b64e_pkg::CHAR_CR;
          chars[3]   = b64e_pkg::CHAR_LF;
          n          = 4;
          line_count = '0;
        end
      end
      default: begin
        // first byte of a group (an out-of-range phase lands here too)
        chars[0]   = b64_char(b[7:2]);
        n          = 1;
        spare_bits = {2'b00, b[1:0]};
        grp_phase  = b64e_pkg::PH_SECOND;
        if (last) begin
          // one byte in the group: flush and two pads
          chars[1] = b64_char({b[1:0], 4'b0000});
          chars[2] = b64e_pkg::CHAR_PAD;
          chars[3] = b64e_pkg::CHAR_PAD;
          n        = 4;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      w.ch      = chars[i];
      w.run_end = (i == n - 1);
      w.msg_end = last && (i == n - 1);
      expected_chars.push_back(w);
    end
    // message done, everything goes back to the reset values
    if (last) begin
      grp_phase  = b64e_pkg::PH_FIRST;
      spare_bits = '0;
      line_count = '0;
    end
  endtask

  // byte side: note the accepted word and predict its characters
  always @(posedge clk) begin
    byte_taken = 1'b0;
    if (!rst && byte_if.valid && byte_if.ready) begin
      byte_taken = 1'b1;
      encode_byte(byte_if.data_byte, byte_if.final_byte);
      pending_bytes.delete(0);
    end
  end

  // byte driver: a word stays on the bus until it is taken, then random gaps
  always @(negedge clk) begin
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else if (byte_if.valid && !byte_taken) begin
      // still waiting for ready, keep the word as it is
    end else if (pending_bytes.size() != 0 && !hold_sender &&
                 (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
      byte_if.valid      <= 1'b1;
      byte_if.data_byte  <= pending_bytes[0].data;
      byte_if.final_byte <= pending_bytes[0].last;
    end else begin
      byte_if.valid <= 1'b0;
    end
  end

  // char side back-pressure
  always @(negedge clk) begin
    char_if.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // char monitor: each word against the oldest expected character
  always @(posedge clk) begin
    if (!rst && char_if.valid && char_if.ready) begin
      if (expected_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected char %h run_end %b message_end %b",
                   char_if.out_char, char_if.run_end, char_if.message_end);
      end else begin
        next_char = expected_chars.pop_front();
        if (char_if.out_char !== next_char.ch || char_if.run_end !== next_char.run_end ||
            char_if.message_end !== next_char.msg_end) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: char exp %h/%b/%b got %h/%b/%b (char/run_end/message_end)",
                     next_char.ch, next_char.run_end, next_char.msg_end,
                     char_if.out_char, char_if.run_end, char_if.message_end);
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    byte_word_t w;
    w.data = b;
    w.last = last;
    pending_bytes.push_back(w);
  endtask

  // random content; the flag only on the last byte when the message closes
  task automatic push_message(input int len, input bit closed);
    for (int i = 0; i < len; i++)
      push_byte(8'($urandom_range(0, 255)), closed && (i == len - 1));
  endtask

  // mostly short messages, now and then long enough to wrap
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 8);
    if (r < 8) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  task automatic push_random_messages(input int total);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      len = pick_length();
      push_message(len, 1'b1);
      sent += len;
    end
  endtask

  // everything sent and every character back
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_if.valid || expected_chars.size() != 0)
      @(posedge clk);
  endtask

  // wrap_lines is only touched with the encoder idle
  task automatic write_wrap(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    wrap_on    = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: short messages ending in each group phase, extreme bytes
    write_wrap(1'b0);
    push_byte(8'h00, 1'b1);                 // one byte, two pads
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFC, 1'b1);
    push_byte(8'h03, 1'b1);
    push_byte(8'hFF, 1'b0);                 // two bytes, one pad
    push_byte(8'hFF, 1'b1);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b1);
    push_byte(8'h00, 1'b0);                 // full group, no pad
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h6E, 1'b1);
    push_byte(8'hF0, 1'b0);                 // runs into a second group
    push_byte(8'h0F, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    wait_drained();

    // wrapping on: 57 bytes is exactly one 76-char line, so the final
    // group is followed by CR LF
    write_wrap(1'b1);
    push_message(57, 1'b1);
    push_message(60, 1'b1);
    push_random_messages(20);
    // let the sender run dry once with the encoder fully drained
    while (pending_bytes.size() > 20) @(posedge clk);
    hold_sender = 1'b1;
    @(negedge clk);
    while (byte_if.valid || expected_chars.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    // count saturates with wrap off, then wrap is switched on mid-message
    write_wrap(1'b0);
    push_message(100, 1'b0);
    wait_drained();
    write_wrap(1'b1);
    push_message(21, 1'b1);
    wait_drained();

    // unwrapped random traffic
    write_wrap(1'b0);
    push_random_messages(20);
    wait_drained();

    // wrapped again: first a stretch with no idling on either side
    write_wrap(1'b1);
    no_gaps = 1'b1;
    push_random_messages(40);
    wait_drained();
    no_gaps = 1'b0;
    push_random_messages(20);
    wait_drained();

    // catch any stray characters after the last expected one
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
